// ----- rtl/adcseq_pkg.sv -----
package adcseq_pkg;

   localparam int MAX_SCAN_ENTRIES   = 8;
   localparam int SAMPLE_BITS        = 10;
   localparam int CHANNEL_BITS       = 5;

   localparam int OP_BITS            = 2;
   localparam int STATUS_BITS        = 2;
   localparam int READING_BITS       = SAMPLE_BITS;
   localparam int LOW_RES_BITS       = 8;
   localparam int READING_INDEX_BITS = 3;

   localparam int SCAN_LENGTH_BITS   = 4;
   localparam int SCAN_CHANNELS_BITS = 40;
   localparam int SCAN_SLOTS         = SCAN_CHANNELS_BITS / CHANNEL_BITS;
   localparam int SCAN_POS_BITS      = 4;
   localparam int VREF_BITS          = 13;
   localparam int MV_BITS            = 13;
   localparam int WAIT_BITS          = 16;
   localparam int PROD_BITS          = READING_BITS + VREF_BITS;

   localparam int PDATA_BITS         = 64;
   localparam int PADDR_BITS         = 6;
   localparam int REG_INDEX_BITS     = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_START_SINGLE = 2'd0,
      OP_START_SCAN   = 2'd1,
      OP_CONV_DONE    = 2'd2,
      OP_TICK         = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_SCAN_LENGTH   = 3'd0,
      REG_SCAN_CHANNELS = 3'd1,
      REG_EIGHT_BIT     = 3'd2,
      REG_VREF          = 3'd3,
      REG_TIMEOUT       = 3'd4
   } reg_index_type;

   localparam logic [SCAN_LENGTH_BITS-1:0]   SCAN_LENGTH_RESET = 4'd1;
   localparam logic [VREF_BITS-1:0]          VREF_RESET        = 13'd5000;
   localparam logic [WAIT_BITS-1:0]          TIMEOUT_RESET     = 16'd50000;

   typedef struct packed {
      logic [SCAN_LENGTH_BITS-1:0]   scan_length;
      logic [SCAN_CHANNELS_BITS-1:0] scan_channels;
      logic                          eight_bit_mode;
      logic [VREF_BITS-1:0]          vref_millivolts;
      logic [WAIT_BITS-1:0]          timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]      operation;
      logic [CHANNEL_BITS-1:0] channel;
      logic                    timed_wait;
      logic [SAMPLE_BITS-1:0]  sample;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]        status;
      logic [CHANNEL_BITS-1:0]       mux_select;
      logic                          start_conversion;
      logic [READING_BITS-1:0]       reading;
      logic                          reading_valid;
      logic [MV_BITS-1:0]            millivolts;
      logic [READING_INDEX_BITS-1:0] reading_index;
      logic                          scan_done;
      logic                          busy_res;
   } rsp_payload_type;

   function automatic logic [CHANNEL_BITS-1:0] scan_entry(
      input logic [SCAN_CHANNELS_BITS-1:0] chans,
      input logic [SCAN_POS_BITS-1:0]      k
   );
      logic [CHANNEL_BITS-1:0] sel;
      sel = '0;
      for (int i = 0; i < SCAN_SLOTS; i++) begin
         if (k == SCAN_POS_BITS'(i)) begin
            sel = chans[i*CHANNEL_BITS +: CHANNEL_BITS];
         end
      end
      return sel;
   endfunction

   function automatic logic [SCAN_POS_BITS-1:0] effective_length(
      input logic [SCAN_LENGTH_BITS-1:0] len
   );
      logic [SCAN_POS_BITS-1:0] eff;
      if (len == '0) begin
         eff = SCAN_POS_BITS'(1);
      end else if (SCAN_POS_BITS'(len) > SCAN_POS_BITS'(MAX_SCAN_ENTRIES)) begin
         eff = SCAN_POS_BITS'(MAX_SCAN_ENTRIES);
      end else begin
         eff = SCAN_POS_BITS'(len);
      end
      return eff;
   endfunction

endpackage

// ----- rtl/adcseq_if.sv -----
interface adcseq_req_if import adcseq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      operation;
   logic [CHANNEL_BITS-1:0] channel;
   logic                    timed_wait;
   logic [SAMPLE_BITS-1:0]  sample;

   modport source (output valid, operation, channel, timed_wait, sample, input ready);
   modport sink   (input valid, operation, channel, timed_wait, sample, output ready);
endinterface

interface adcseq_rsp_if import adcseq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [STATUS_BITS-1:0]        status;
   logic [CHANNEL_BITS-1:0]       mux_select;
   logic                          start_conversion;
   logic [READING_BITS-1:0]       reading;
   logic                          reading_valid;
   logic [MV_BITS-1:0]            millivolts;
   logic [READING_INDEX_BITS-1:0] reading_index;
   logic                          scan_done;
   logic                          busy_res;

   modport source (output valid, status, mux_select, start_conversion, reading,
                   reading_valid, millivolts, reading_index, scan_done, busy_res,
                   input ready);
   modport sink   (input valid, status, mux_select, start_conversion, reading,
                   reading_valid, millivolts, reading_index, scan_done, busy_res,
                   output ready);
endinterface

// ----- rtl/adcseq_csr.sv -----
module adcseq_csr import adcseq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic                      wr_en;
   logic [REG_INDEX_BITS-1:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[PADDR_BITS-1:PADDR_BITS-REG_INDEX_BITS];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_SCAN_LENGTH:   cfg_in.scan_length     = pwdata[SCAN_LENGTH_BITS-1:0];
            REG_SCAN_CHANNELS: cfg_in.scan_channels   = pwdata[SCAN_CHANNELS_BITS-1:0];
            REG_EIGHT_BIT:     cfg_in.eight_bit_mode  = pwdata[0];
            REG_VREF:          cfg_in.vref_millivolts = pwdata[VREF_BITS-1:0];
            REG_TIMEOUT:       cfg_in.timeout_ticks   = pwdata[WAIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SCAN_LENGTH:   prdata = PDATA_BITS'(cfg_ff.scan_length);
         REG_SCAN_CHANNELS: prdata = PDATA_BITS'(cfg_ff.scan_channels);
         REG_EIGHT_BIT:     prdata = PDATA_BITS'(cfg_ff.eight_bit_mode);
         REG_VREF:          prdata = PDATA_BITS'(cfg_ff.vref_millivolts);
         REG_TIMEOUT:       prdata = PDATA_BITS'(cfg_ff.timeout_ticks);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_length     <= SCAN_LENGTH_RESET;
         cfg_ff.scan_channels   <= '0;
         cfg_ff.eight_bit_mode  <= 1'b0;
         cfg_ff.vref_millivolts <= VREF_RESET;
         cfg_ff.timeout_ticks   <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/adcseq_ctrl.sv -----
module adcseq_ctrl import adcseq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   adcseq_req_if.sink      req_bus,
   input  cfg_type         cfg,
   output logic            res_valid,
   input  logic            res_ready,
   output rsp_payload_type res
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   req_payload_type          in_data_ff;
   req_payload_type          in_data_in;
   logic                     req_take;
   logic                     fire;

   logic                     busy_ff;
   logic                     busy_in;
   logic                     scan_mode_ff;
   logic                     scan_mode_in;
   logic [SCAN_POS_BITS-1:0] scan_pos_ff;
   logic [SCAN_POS_BITS-1:0] scan_pos_in;
   logic [WAIT_BITS-1:0]     wait_count_ff;
   logic [WAIT_BITS-1:0]     wait_count_in;
   logic                     timed_single_ff;
   logic                     timed_single_in;

   logic [READING_BITS-1:0]  rd;
   logic [PROD_BITS-1:0]     product;
   logic [SCAN_POS_BITS-1:0] pos_next;
   logic [WAIT_BITS-1:0]     wait_next;

   assign fire          = in_valid_ff && res_ready;
   assign req_bus.ready = !in_valid_ff || fire;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign res_valid     = in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      in_data_in            = in_data_ff;
      if (req_take) begin
         in_data_in.operation  = req_bus.operation;
         in_data_in.channel    = req_bus.channel;
         in_data_in.timed_wait = req_bus.timed_wait;
         in_data_in.sample     = req_bus.sample;
      end
   end

   always_comb begin
      if (cfg.eight_bit_mode) begin
         rd = READING_BITS'(in_data_ff.sample >> (SAMPLE_BITS - LOW_RES_BITS));
      end else begin
         rd = in_data_ff.sample;
      end
      product   = PROD_BITS'(rd) * PROD_BITS'(cfg.vref_millivolts);
      pos_next  = scan_pos_ff + SCAN_POS_BITS'(1);
      wait_next = wait_count_ff + WAIT_BITS'(1);
   end

   always_comb begin
      busy_in         = busy_ff;
      scan_mode_in    = scan_mode_ff;
      scan_pos_in     = scan_pos_ff;
      wait_count_in   = wait_count_ff;
      timed_single_in = timed_single_ff;
      res             = '0;
      res.status      = ST_OK;

      case (in_data_ff.operation)
         OP_START_SINGLE, OP_START_SCAN: begin
            if (busy_ff) begin
               res.status = ST_BUSY;
            end else begin
               busy_in              = 1'b1;
               wait_count_in        = '0;
               res.start_conversion = 1'b1;
               if (in_data_ff.operation == OP_START_SINGLE) begin
                  scan_mode_in    = 1'b0;
                  timed_single_in = in_data_ff.timed_wait;
                  res.mux_select  = in_data_ff.channel;
               end else begin
                  scan_mode_in    = 1'b1;
                  timed_single_in = 1'b0;
                  scan_pos_in     = '0;
                  res.mux_select  = scan_entry(cfg.scan_channels, '0);
               end
            end
         end
         OP_CONV_DONE: begin
            if (!busy_ff) begin
               res.status = ST_IGNORED;
            end else begin
               res.reading       = rd;
               res.reading_valid = 1'b1;
               if (cfg.eight_bit_mode) begin
                  res.millivolts = MV_BITS'(product >> LOW_RES_BITS);
               end else begin
                  res.millivolts = MV_BITS'(product >> SAMPLE_BITS);
               end
               if (!scan_mode_ff) begin
                  res.scan_done   = 1'b1;
                  busy_in         = 1'b0;
                  timed_single_in = 1'b0;
                  wait_count_in   = '0;
               end else begin
                  res.reading_index = READING_INDEX_BITS'(scan_pos_ff);
                  scan_pos_in       = pos_next;
                  if (pos_next >= effective_length(cfg.scan_length)) begin
                     res.scan_done = 1'b1;
                     busy_in       = 1'b0;
                  end else begin
                     res.start_conversion = 1'b1;
                     res.mux_select       = scan_entry(cfg.scan_channels, pos_next);
                  end
               end
            end
         end
         OP_TICK: begin
            if (busy_ff && !scan_mode_ff && timed_single_ff) begin
               wait_count_in = wait_next;
               if (wait_next >= cfg.timeout_ticks) begin
                  res.status      = ST_TIMEOUT;
                  busy_in         = 1'b0;
                  timed_single_in = 1'b0;
                  wait_count_in   = '0;
               end
            end else begin
               res.status = ST_IGNORED;
            end
         end
         default: res.status = ST_IGNORED;
      endcase

      res.busy_res = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         busy_ff         <= 1'b0;
         scan_mode_ff    <= 1'b0;
         scan_pos_ff     <= '0;
         wait_count_ff   <= '0;
         timed_single_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            busy_ff         <= busy_in;
            scan_mode_ff    <= scan_mode_in;
            scan_pos_ff     <= scan_pos_in;
            wait_count_ff   <= wait_count_in;
            timed_single_ff <= timed_single_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   a_timed_only_single: assert property (@(posedge clock) disable iff (reset)
      timed_single_ff |-> (busy_ff && !scan_mode_ff))
      else $error("timed flag set outside a single conversion");

   a_wait_needs_timed: assert property (@(posedge clock) disable iff (reset)
      (wait_count_ff != '0) |-> timed_single_ff)
      else $error("wait count running without a timed conversion");

   a_start_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && res.start_conversion) |-> res.busy_res)
      else $error("conversion started while going idle");

   a_reading_ok: assert property (@(posedge clock) disable iff (reset)
      (fire && res.reading_valid) |-> (res.status == ST_OK))
      else $error("reading delivered with error status");

endmodule

// ----- rtl/adcseq_out_stage.sv -----
module adcseq_out_stage import adcseq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   output logic            res_ready,
   input  rsp_payload_type res,
   adcseq_rsp_if.source    rsp_bus
);

   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            load;

   assign res_ready = !out_valid_ff || rsp_bus.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      out_data_in = load ? res : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.status           = out_data_ff.status;
   assign rsp_bus.mux_select       = out_data_ff.mux_select;
   assign rsp_bus.start_conversion = out_data_ff.start_conversion;
   assign rsp_bus.reading          = out_data_ff.reading;
   assign rsp_bus.reading_valid    = out_data_ff.reading_valid;
   assign rsp_bus.millivolts       = out_data_ff.millivolts;
   assign rsp_bus.reading_index    = out_data_ff.reading_index;
   assign rsp_bus.scan_done        = out_data_ff.scan_done;
   assign rsp_bus.busy_res         = out_data_ff.busy_res;

endmodule

// ----- rtl/adc_scan_sequencer.sv -----
// ADC scan sequencer.
// Input channel req_bus carries one event per transaction: start single, start
// scan, conversion complete or tick, with channel, timed flag and raw sample.
// Result channel rsp_bus returns exactly one transaction per event: status,
// the multiplexer channel to start (if any), the reading in full or 8-bit
// resolution with its millivolt value and scan index, scan done and busy.
// Registers (scan length, channel list, 8-bit mode, reference, timeout) sit
// on an APB-style port at byte addresses 8*i, 64-bit data; write only while
// no transaction is in flight.
// An accepted event lands in the input register; its result is computed from
// that register and loads into the result register, from which it is offered
// on rsp_bus. Throughput: one event per cycle while the result register is free
// to load, set by the combinational state update between the two registers.
// When rsp_bus.ready is low the result register holds, one more event waits
// in the input register, and req_bus.ready then drops until the result leaves.
// Reset: synchronous, active high; clears busy, mode, scan position, timeout
// count and both pipeline valids, and loads the register reset values.
module adc_scan_sequencer import adcseq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   adcseq_req_if.sink            req_bus,
   adcseq_rsp_if.source          rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   logic            res_valid;
   logic            res_ready;
   rsp_payload_type res;

   adcseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   adcseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   adcseq_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- test/tb_adc_scan_sequencer.sv -----
`timescale 1ns / 100ps

module tb_adc_scan_sequencer;
   import adcseq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic                  pready;

   adcseq_req_if req_bus();
   adcseq_rsp_if rsp_bus();

   adc_scan_sequencer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [SCAN_LENGTH_BITS-1:0]   len_cfg;
   logic [SCAN_CHANNELS_BITS-1:0] chans_cfg;
   logic                          eight_cfg;
   logic [VREF_BITS-1:0]          vref_cfg;
   logic [WAIT_BITS-1:0]          timeout_cfg;

   logic                     busy_q;
   logic                     scanning_q;
   logic [SCAN_POS_BITS-1:0] position_q;
   logic [WAIT_BITS-1:0]     tick_count_q;
   logic                     timed_q;

   rsp_payload_type awaited_results[$];
   rsp_payload_type expected_head;

   int  fail_count;
   int  accepted_count;
   int  cycle_count;
   int  idle_pct;
   int  stall_pct;
   logic valid_held;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("adc_scan_sequencer test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic logic [CHANNEL_BITS-1:0] list_channel(input logic [SCAN_POS_BITS-1:0] k);
      if (int'(k) * CHANNEL_BITS >= SCAN_CHANNELS_BITS) begin
         return '0;
      end
      return chans_cfg[int'(k) * CHANNEL_BITS +: CHANNEL_BITS];
   endfunction

   function automatic logic [SCAN_POS_BITS-1:0] scan_limit();
      if (len_cfg == '0) begin
         return SCAN_POS_BITS'(1);
      end else if (int'(len_cfg) > MAX_SCAN_ENTRIES) begin
         return SCAN_POS_BITS'(MAX_SCAN_ENTRIES);
      end
      return SCAN_POS_BITS'(len_cfg);
   endfunction

   function automatic rsp_payload_type predict_sequencer_result(input req_payload_type ev);
      rsp_payload_type        r;
      logic [READING_BITS-1:0] rd;
      logic [PROD_BITS-1:0]    prod;
      r = '0;
      case (ev.operation)
         OP_START_SINGLE, OP_START_SCAN: begin
            if (busy_q) begin
               r.status = ST_BUSY;
            end else begin
               busy_q = 1'b1;
               tick_count_q = '0;
               r.start_conversion = 1'b1;
               if (ev.operation == OP_START_SINGLE) begin
                  scanning_q = 1'b0;
                  timed_q = ev.timed_wait;
                  r.mux_select = ev.channel;
               end else begin
                  scanning_q = 1'b1;
                  timed_q = 1'b0;
                  position_q = '0;
                  r.mux_select = list_channel('0);
               end
            end
         end
         OP_CONV_DONE: begin
            if (!busy_q) begin
               r.status = ST_IGNORED;
            end else begin
               rd = eight_cfg ? READING_BITS'(ev.sample[SAMPLE_BITS-1 -: LOW_RES_BITS])
                              : ev.sample;
               prod = PROD_BITS'(rd) * PROD_BITS'(vref_cfg);
               r.reading = rd;
               r.reading_valid = 1'b1;
               r.millivolts = eight_cfg ? MV_BITS'(prod >> LOW_RES_BITS)
                                        : MV_BITS'(prod >> SAMPLE_BITS);
               if (!scanning_q) begin
                  r.scan_done = 1'b1;
                  busy_q = 1'b0;
                  timed_q = 1'b0;
                  tick_count_q = '0;
               end else begin
                  r.reading_index = READING_INDEX_BITS'(position_q);
                  position_q = position_q + SCAN_POS_BITS'(1);
                  if (position_q >= scan_limit()) begin
                     r.scan_done = 1'b1;
                     busy_q = 1'b0;
                  end else begin
                     r.start_conversion = 1'b1;
                     r.mux_select = list_channel(position_q);
                  end
               end
            end
         end
         default: begin
            if (busy_q && !scanning_q && timed_q) begin
               tick_count_q = tick_count_q + WAIT_BITS'(1);
               if (tick_count_q >= timeout_cfg) begin
                  r.status = ST_TIMEOUT;
                  busy_q = 1'b0;
                  timed_q = 1'b0;
                  tick_count_q = '0;
               end
            end else begin
               r.status = ST_IGNORED;
            end
         end
      endcase
      r.busy_res = busy_q;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $error("result transaction with no event pending");
            fail_count++;
         end else begin
            expected_head = awaited_results.pop_front();
            check_field("status", 16'(expected_head.status), 16'(rsp_bus.status));
            check_field("mux_select", 16'(expected_head.mux_select),
                        16'(rsp_bus.mux_select));
            check_field("start_conversion", 16'(expected_head.start_conversion),
                        16'(rsp_bus.start_conversion));
            check_field("reading", 16'(expected_head.reading), 16'(rsp_bus.reading));
            check_field("reading_valid", 16'(expected_head.reading_valid),
                        16'(rsp_bus.reading_valid));
            check_field("millivolts", 16'(expected_head.millivolts),
                        16'(rsp_bus.millivolts));
            check_field("reading_index", 16'(expected_head.reading_index),
                        16'(rsp_bus.reading_index));
            check_field("scan_done", 16'(expected_head.scan_done), 16'(rsp_bus.scan_done));
            check_field("busy_res", 16'(expected_head.busy_res), 16'(rsp_bus.busy_res));
         end
      end
   end

   task automatic send_event(input op_type op, input logic [CHANNEL_BITS-1:0] ch,
                             input logic timed, input logic [SAMPLE_BITS-1:0] smp);
      req_payload_type ev;
      rsp_payload_type r;
      ev = {op, ch, timed, smp};
      while ($urandom_range(0, 99) < idle_pct) begin
         if (valid_held) begin
            req_bus.valid <= 1'b0;
            valid_held = 1'b0;
         end
         @(posedge clock);
      end
      req_bus.operation  <= op;
      req_bus.channel    <= ch;
      req_bus.timed_wait <= timed;
      req_bus.sample     <= smp;
      if (!valid_held) begin
         req_bus.valid <= 1'b1;
         valid_held = 1'b1;
      end
      do @(posedge clock); while (!req_bus.ready);
      r = predict_sequencer_result(ev);
      awaited_results.push_back(r);
      accepted_count++;
   endtask

   task automatic send_random(input op_type op);
      send_event(op, CHANNEL_BITS'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                 SAMPLE_BITS'($urandom_range(0, 1023)));
   endtask

   task automatic release_request();
      if (valid_held) begin
         req_bus.valid <= 1'b0;
         valid_held = 1'b0;
      end
      @(posedge clock);
   endtask

   task automatic wait_results_drained();
      release_request();
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [PDATA_BITS-1:0] value);
      logic [PDATA_BITS-1:0] stored;
      stored = '0;
      case (idx)
         REG_SCAN_LENGTH: begin
            len_cfg = value[SCAN_LENGTH_BITS-1:0];
            stored = PDATA_BITS'(len_cfg);
         end
         REG_SCAN_CHANNELS: begin
            chans_cfg = value[SCAN_CHANNELS_BITS-1:0];
            stored = PDATA_BITS'(chans_cfg);
         end
         REG_EIGHT_BIT: begin
            eight_cfg = value[0];
            stored = PDATA_BITS'(eight_cfg);
         end
         REG_VREF: begin
            vref_cfg = value[VREF_BITS-1:0];
            stored = PDATA_BITS'(vref_cfg);
         end
         default: begin
            timeout_cfg = value[WAIT_BITS-1:0];
            stored = PDATA_BITS'(timeout_cfg);
         end
      endcase
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= PADDR_BITS'({idx, 3'b000});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored) begin
         $error("register %s: expected %0h, actual %0h", idx.name(), stored, prdata);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_idle_events();
      send_event(OP_CONV_DONE, 5'd31, 1'b1, 10'd1023);
      send_event(OP_TICK, 5'd0, 1'b0, 10'd0);
   endtask

   task automatic test_single_conversion();
      send_event(OP_START_SINGLE, 5'd31, 1'b0, 10'd0);
      send_event(OP_START_SCAN, 5'd0, 1'b0, 10'd0);
      send_event(OP_START_SINGLE, 5'd7, 1'b1, 10'd512);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd1023);
      send_event(OP_START_SINGLE, 5'd0, 1'b0, 10'd1023);
      send_event(OP_CONV_DONE, 5'd31, 1'b1, 10'd0);
   endtask

   task automatic test_eight_bit_mode();
      wait_results_drained();
      csr_write(REG_EIGHT_BIT, 64'd1);
      send_event(OP_START_SINGLE, 5'd21, 1'b0, 10'd0);
      send_event(OP_CONV_DONE, 5'd10, 1'b0, 10'd1023);
      wait_results_drained();
      csr_write(REG_EIGHT_BIT, 64'd0);
   endtask

   task automatic test_channel_scan();
      wait_results_drained();
      csr_write(REG_SCAN_LENGTH, 64'd3);
      csr_write(REG_SCAN_CHANNELS, 64'h00_0000_7C1F);
      send_event(OP_START_SCAN, 5'd5, 1'b1, 10'd0);
      send_event(OP_TICK, 5'd0, 1'b1, 10'd0);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd341);
      send_event(OP_START_SINGLE, 5'd3, 1'b0, 10'd0);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd682);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd1023);
   endtask

   task automatic test_timeout_abort();
      wait_results_drained();
      csr_write(REG_TIMEOUT, 64'd2);
      send_event(OP_START_SINGLE, 5'd12, 1'b1, 10'd0);
      send_event(OP_TICK, 5'd0, 1'b0, 10'd0);
      send_event(OP_TICK, 5'd0, 1'b0, 10'd0);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd100);
      wait_results_drained();
      csr_write(REG_TIMEOUT, 64'd0);
      send_event(OP_START_SINGLE, 5'd1, 1'b1, 10'd0);
      send_event(OP_TICK, 5'd0, 1'b1, 10'd0);
      send_event(OP_START_SINGLE, 5'd2, 1'b0, 10'd0);
      send_event(OP_TICK, 5'd0, 1'b1, 10'd0);
      send_event(OP_CONV_DONE, 5'd0, 1'b0, 10'd777);
   endtask

   task automatic run_phase(input logic [SCAN_LENGTH_BITS-1:0] len,
                            input logic [SCAN_CHANNELS_BITS-1:0] chans,
                            input logic eight, input logic [VREF_BITS-1:0] vref,
                            input logic [WAIT_BITS-1:0] tmo,
                            input int sender_idle, input int receiver_stall,
                            input int target);
      int first;
      int pick;
      int n_ticks;
      wait_results_drained();
      csr_write(REG_SCAN_LENGTH, PDATA_BITS'(len));
      csr_write(REG_SCAN_CHANNELS, PDATA_BITS'(chans));
      csr_write(REG_EIGHT_BIT, PDATA_BITS'(eight));
      csr_write(REG_VREF, PDATA_BITS'(vref));
      csr_write(REG_TIMEOUT, PDATA_BITS'(tmo));
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      first = accepted_count;
      while (accepted_count - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_random(OP_START_SCAN);
            while (busy_q && scanning_q) begin
               if ($urandom_range(0, 99) < 15) begin
                  send_random(op_type'($urandom_range(0, 3)));
               end else begin
                  send_random(OP_CONV_DONE);
               end
            end
         end else if (pick < 80) begin
            send_random(OP_START_SINGLE);
            n_ticks = $urandom_range(0, 24);
            for (int i = 0; i < n_ticks && busy_q && !scanning_q; i++) begin
               send_random(OP_TICK);
            end
            if (busy_q && $urandom_range(0, 9) != 0) begin
               send_random(OP_CONV_DONE);
            end
         end else begin
            send_random(op_type'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_random_phases();
      run_phase(4'd8, SCAN_CHANNELS_BITS'({$urandom(), $urandom()}), 1'b0, 13'd5000,
                16'd3, 0, 0, 230);
      run_phase(4'd1, {SCAN_CHANNELS_BITS{1'b1}}, 1'b1, 13'd0, 16'd1, 54, 0, 230);
      run_phase(4'd0, SCAN_CHANNELS_BITS'({$urandom(), $urandom()}), 1'b0, 13'd1,
                16'd0, 0, 54, 230);
      run_phase(4'd15, SCAN_CHANNELS_BITS'({$urandom(), $urandom()}), 1'b1, 13'd5000,
                16'd65535, 9, 9, 230);
      run_phase(SCAN_LENGTH_BITS'($urandom_range(1, 8)),
                SCAN_CHANNELS_BITS'({$urandom(), $urandom()}), 1'($urandom_range(0, 1)),
                VREF_BITS'($urandom_range(0, 5000)), WAIT_BITS'($urandom_range(1, 12)),
                0, 0, 230);
      run_phase(SCAN_LENGTH_BITS'($urandom_range(2, 7)),
                SCAN_CHANNELS_BITS'({$urandom(), $urandom()}), 1'($urandom_range(0, 1)),
                VREF_BITS'($urandom_range(0, 5000)), WAIT_BITS'($urandom_range(2, 20)),
                54, 54, 230);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_START_SINGLE;
      req_bus.channel = '0;
      req_bus.timed_wait = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      valid_held = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      fail_count = 0;
      accepted_count = 0;
      cycle_count = 0;
      len_cfg = SCAN_LENGTH_RESET;
      chans_cfg = '0;
      eight_cfg = 1'b0;
      vref_cfg = VREF_RESET;
      timeout_cfg = TIMEOUT_RESET;
      busy_q = 1'b0;
      scanning_q = 1'b0;
      position_q = '0;
      tick_count_q = '0;
      timed_q = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_events();
      test_single_conversion();
      test_eight_bit_mode();
      test_channel_scan();
      test_timeout_abort();
      test_random_phases();
      wait_results_drained();
      if (fail_count == 0) begin
         $display("adc_scan_sequencer test passed");
      end else begin
         $display("adc_scan_sequencer test failed");
      end
      $finish;
   end

endmodule
